// ----- src/b2y422_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2y422_pkg
// shared constants and types for the bgr to ycbcr 4:2:2 pair converter
// ----------------------------------------------------------------------------
package b2y422_pkg;

    localparam int COEFF_FRAC_BITS = 16;
    localparam int PIX_W           = 8;
    localparam int COEF_W          = COEFF_FRAC_BITS;
    localparam int PROD_W          = COEF_W + PIX_W;
    localparam int SUM_W           = COEFF_FRAC_BITS + 10;
    localparam int INT_W           = SUM_W - COEFF_FRAC_BITS;
    localparam int IN_TDATA_W      = 6 * PIX_W;
    localparam int OUT_TDATA_W     = 4 * PIX_W;

    // coefficients in thousandths, rounded half up to fixed point
    localparam logic [COEF_W-1:0] COEF_Y_B  =
        COEF_W'(((64'd98  << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] COEF_Y_G  =
        COEF_W'(((64'd504 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] COEF_Y_R  =
        COEF_W'(((64'd257 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] COEF_C_P  =
        COEF_W'(((64'd439 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] COEF_CB_G =
        COEF_W'(((64'd291 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] COEF_CB_R =
        COEF_W'(((64'd148 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] COEF_CR_B =
        COEF_W'(((64'd71  << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] COEF_CR_G =
        COEF_W'(((64'd368 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);

    localparam logic [SUM_W-1:0] OFFSET_Y = SUM_W'(64'd16  << COEFF_FRAC_BITS);
    localparam logic [SUM_W-1:0] OFFSET_C = SUM_W'(64'd128 << COEFF_FRAC_BITS);
    localparam logic [INT_W-1:0] BYTE_MAX = INT_W'(255);

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [PROD_W-1:0] y_b;
        logic [PROD_W-1:0] y_g;
        logic [PROD_W-1:0] y_r;
        logic [PROD_W-1:0] cb_b;
        logic [PROD_W-1:0] cb_g;
        logic [PROD_W-1:0] cb_r;
        logic [PROD_W-1:0] cr_b;
        logic [PROD_W-1:0] cr_g;
        logic [PROD_W-1:0] cr_r;
    } prod_t;

    typedef struct packed {
        logic [SUM_W-1:0] y;
        logic [SUM_W-1:0] cb_pos;
        logic [SUM_W-1:0] cb_neg;
        logic [SUM_W-1:0] cr_pos;
        logic [SUM_W-1:0] cr_neg;
    } sum_t;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } chan_t;

endpackage

// ----- src/bgra_to_ycbcr422_pair.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgra_to_ycbcr422_pair
// converts two adjacent bgr pixels to two luma bytes and one cb/cr pair
// ----------------------------------------------------------------------------
// s_axis carries one pixel pair per request, m_axis one 4:2:2 result per
// request. bt.601 studio-range coefficients, truncated sums, results
// clamped to 0..255, chroma averaged over the pair with truncation.
// four register stages: products, sums, per-pixel bytes, chroma average
// and output register. one request per cycle is sustained while m_axis_tready
// stays high; the multiply stage sets the cycle time.
// when m_axis_tready is low the output register holds; s_axis_tready drops
// only once all four stages hold a request, so nothing is lost or repeated.
// reset clears the stage valid bits; the pipeline is empty afterwards and
// s_axis_tready is high.
// ----------------------------------------------------------------------------
module bgra_to_ycbcr422_pair
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // first_blue, first_green, first_red, second_blue, second_green, second_red
    input  logic [b2y422_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // first_luma, second_luma, blue_chroma, red_chroma
    output logic [b2y422_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int PW = b2y422_pkg::PIX_W;

    function automatic logic [b2y422_pkg::PROD_W-1:0] scale(
        input logic [PW-1:0]                 pix,
        input logic [b2y422_pkg::COEF_W-1:0] coef
    );
        scale = b2y422_pkg::PROD_W'(pix) * b2y422_pkg::PROD_W'(coef);
    endfunction

    function automatic logic [PW-1:0] to_byte(
        input logic [b2y422_pkg::SUM_W-1:0] pos,
        input logic [b2y422_pkg::SUM_W-1:0] neg
    );
        logic [b2y422_pkg::SUM_W-1:0] diff;
        logic [b2y422_pkg::INT_W-1:0] whole;
        diff  = pos - neg;
        whole = diff[b2y422_pkg::SUM_W-1:b2y422_pkg::COEFF_FRAC_BITS];
        if (pos < neg)
            to_byte = '0;
        else if (whole > b2y422_pkg::BYTE_MAX)
            to_byte = '1;
        else
            to_byte = whole[PW-1:0];
    endfunction

    b2y422_pkg::pixel_t  pix_in [2];

    logic                st1_valid_reg, st1_valid_next;
    logic                st2_valid_reg, st2_valid_next;
    logic                st3_valid_reg, st3_valid_next;
    logic                st4_valid_reg, st4_valid_next;
    logic                ready1, ready2, ready3, ready4;

    b2y422_pkg::prod_t   st1_prod_reg [2];
    b2y422_pkg::prod_t   st1_prod_next [2];
    b2y422_pkg::sum_t    st2_sum_reg [2];
    b2y422_pkg::sum_t    st2_sum_next [2];
    b2y422_pkg::chan_t   st3_chan_reg [2];
    b2y422_pkg::chan_t   st3_chan_next [2];
    logic [b2y422_pkg::OUT_TDATA_W-1:0] st4_data_reg, st4_data_next;

    logic [PW:0]         cb_pair, cr_pair;

    // handshake chain
    assign ready4 = !st4_valid_reg || m_axis_tready;
    assign ready3 = !st3_valid_reg || ready4;
    assign ready2 = !st2_valid_reg || ready3;
    assign ready1 = !st1_valid_reg || ready2;

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = st4_valid_reg;
    assign m_axis_tdata  = st4_data_reg;

    assign pix_in[0].blue  = s_axis_tdata[PW*1-1:PW*0];
    assign pix_in[0].green = s_axis_tdata[PW*2-1:PW*1];
    assign pix_in[0].red   = s_axis_tdata[PW*3-1:PW*2];
    assign pix_in[1].blue  = s_axis_tdata[PW*4-1:PW*3];
    assign pix_in[1].green = s_axis_tdata[PW*5-1:PW*4];
    assign pix_in[1].red   = s_axis_tdata[PW*6-1:PW*5];

    always_comb
    begin
        st1_valid_next = ready1 ? s_axis_tvalid : st1_valid_reg;
        st2_valid_next = ready2 ? st1_valid_reg : st2_valid_reg;
        st3_valid_next = ready3 ? st2_valid_reg : st3_valid_reg;
        st4_valid_next = ready4 ? st3_valid_reg : st4_valid_reg;
    end

    // stage 1: constant products
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            st1_prod_next[i].y_b  = scale(pix_in[i].blue,  b2y422_pkg::COEF_Y_B);
            st1_prod_next[i].y_g  = scale(pix_in[i].green, b2y422_pkg::COEF_Y_G);
            st1_prod_next[i].y_r  = scale(pix_in[i].red,   b2y422_pkg::COEF_Y_R);
            st1_prod_next[i].cb_b = scale(pix_in[i].blue,  b2y422_pkg::COEF_C_P);
            st1_prod_next[i].cb_g = scale(pix_in[i].green, b2y422_pkg::COEF_CB_G);
            st1_prod_next[i].cb_r = scale(pix_in[i].red,   b2y422_pkg::COEF_CB_R);
            st1_prod_next[i].cr_b = scale(pix_in[i].blue,  b2y422_pkg::COEF_CR_B);
            st1_prod_next[i].cr_g = scale(pix_in[i].green, b2y422_pkg::COEF_CR_G);
            st1_prod_next[i].cr_r = scale(pix_in[i].red,   b2y422_pkg::COEF_C_P);
        end
    end

    // stage 2: weighted sums with offsets
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            st2_sum_next[i].y      = b2y422_pkg::SUM_W'(st1_prod_reg[i].y_b)
                                   + b2y422_pkg::SUM_W'(st1_prod_reg[i].y_g)
                                   + b2y422_pkg::SUM_W'(st1_prod_reg[i].y_r)
                                   + b2y422_pkg::OFFSET_Y;
            st2_sum_next[i].cb_pos = b2y422_pkg::SUM_W'(st1_prod_reg[i].cb_b)
                                   + b2y422_pkg::OFFSET_C;
            st2_sum_next[i].cb_neg = b2y422_pkg::SUM_W'(st1_prod_reg[i].cb_g)
                                   + b2y422_pkg::SUM_W'(st1_prod_reg[i].cb_r);
            st2_sum_next[i].cr_pos = b2y422_pkg::SUM_W'(st1_prod_reg[i].cr_r)
                                   + b2y422_pkg::OFFSET_C;
            st2_sum_next[i].cr_neg = b2y422_pkg::SUM_W'(st1_prod_reg[i].cr_b)
                                   + b2y422_pkg::SUM_W'(st1_prod_reg[i].cr_g);
        end
    end

    // stage 3: truncate and clamp per pixel
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            st3_chan_next[i].y  = to_byte(st2_sum_reg[i].y, '0);
            st3_chan_next[i].cb = to_byte(st2_sum_reg[i].cb_pos, st2_sum_reg[i].cb_neg);
            st3_chan_next[i].cr = to_byte(st2_sum_reg[i].cr_pos, st2_sum_reg[i].cr_neg);
        end
    end

    // stage 4: chroma average over the pair
    always_comb
    begin
        cb_pair       = {1'b0, st3_chan_reg[0].cb} + {1'b0, st3_chan_reg[1].cb};
        cr_pair       = {1'b0, st3_chan_reg[0].cr} + {1'b0, st3_chan_reg[1].cr};
        st4_data_next = {cr_pair[PW:1], cb_pair[PW:1],
                         st3_chan_reg[1].y, st3_chan_reg[0].y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            st3_valid_reg <= st3_valid_next;
            st4_valid_reg <= st4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
            st1_prod_reg <= st1_prod_next;
        if (ready2)
            st2_sum_reg <= st2_sum_next;
        if (ready3)
            st3_chan_reg <= st3_chan_next;
        if (ready4)
            st4_data_reg <= st4_data_next;
    end

    // studio range holds for byte inputs
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] >= 8'd16) && (m_axis_tdata[7:0] <= 8'd235)
                       && (m_axis_tdata[15:8] >= 8'd16) && (m_axis_tdata[15:8] <= 8'd235))
        else $error("luma outside studio range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:16] >= 8'd16) && (m_axis_tdata[23:16] <= 8'd240)
                       && (m_axis_tdata[31:24] >= 8'd16) && (m_axis_tdata[31:24] <= 8'd240))
        else $error("chroma outside studio range");

    // back pressure only when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> st1_valid_reg && st2_valid_reg && st3_valid_reg
                           && st4_valid_reg && !m_axis_tready)
        else $error("input stalled with a free stage");

    // an accepted request reaches stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> st1_valid_reg)
        else $error("accepted request dropped");

endmodule

// ----- verif/bgra_to_ycbcr422_pair_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgra_to_ycbcr422_pair_tb
// self-checking bench for the bgr pixel pair to ycbcr 4:2:2 converter
// ----------------------------------------------------------------------------
// pixel pairs go in on s_axis. each accepted request gets its expected 4:2:2
// result from a local bt.601 fixed-point model, and the checker compares
// every m_axis request against the oldest expectation. directed extremes and
// primaries come first, then random pairs with random gaps on both sides,
// a burst with no gaps, a long output hold-off that backs the pipe up, and a
// pause that lets the pipe drain completely.
// ----------------------------------------------------------------------------
module bgra_to_ycbcr422_pair_tb;

    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 8;

    // packed so that first_blue lands in the lowest byte
    typedef struct packed {
        logic [b2y422_pkg::PIX_W-1:0] second_red;
        logic [b2y422_pkg::PIX_W-1:0] second_green;
        logic [b2y422_pkg::PIX_W-1:0] second_blue;
        logic [b2y422_pkg::PIX_W-1:0] first_red;
        logic [b2y422_pkg::PIX_W-1:0] first_green;
        logic [b2y422_pkg::PIX_W-1:0] first_blue;
    } bgr_pair_t;

    typedef struct packed {
        logic [b2y422_pkg::PIX_W-1:0] red_chroma;
        logic [b2y422_pkg::PIX_W-1:0] blue_chroma;
        logic [b2y422_pkg::PIX_W-1:0] second_luma;
        logic [b2y422_pkg::PIX_W-1:0] first_luma;
    } ycc_pair_t;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // first_blue, first_green, first_red, second_blue, second_green, second_red
    logic [b2y422_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // first_luma, second_luma, blue_chroma, red_chroma
    logic [b2y422_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    ycc_pair_t ycc_due[$];
    int        fail_count = 0;
    int        result_count = 0;
    logic      quiet = 1'b0;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    bgra_to_ycbcr422_pair dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("bgra_to_ycbcr422_pair_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // bt.601 fixed-point model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] fixed_coef(input int unsigned milli);
        return ((64'(milli) << b2y422_pkg::COEFF_FRAC_BITS) + 64'd500) / 64'd1000;
    endfunction

    function automatic logic [7:0] to_byte(input logic [63:0] pos, input logic [63:0] neg);
        logic [63:0] whole;
        if (pos < neg)
            return 8'd0;
        whole = (pos - neg) >> b2y422_pkg::COEFF_FRAC_BITS;
        return (whole > 64'd255) ? 8'hff : whole[7:0];
    endfunction

    function automatic logic [7:0] luma_byte(input logic [7:0] b, input logic [7:0] g,
                                             input logic [7:0] r);
        return to_byte(fixed_coef(98) * b + fixed_coef(504) * g + fixed_coef(257) * r
                       + (64'd16 << b2y422_pkg::COEFF_FRAC_BITS), 64'd0);
    endfunction

    function automatic logic [7:0] cb_byte(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        return to_byte(fixed_coef(439) * b + (64'd128 << b2y422_pkg::COEFF_FRAC_BITS),
                       fixed_coef(291) * g + fixed_coef(148) * r);
    endfunction

    function automatic logic [7:0] cr_byte(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        return to_byte(fixed_coef(439) * r + (64'd128 << b2y422_pkg::COEFF_FRAC_BITS),
                       fixed_coef(71) * b + fixed_coef(368) * g);
    endfunction

    function automatic logic [7:0] pair_mean(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] total;
        total = {1'b0, a} + {1'b0, b};
        total = total >> 1;
        return (total > 9'd255) ? 8'hff : total[7:0];
    endfunction

    function automatic ycc_pair_t bt601_pair(input bgr_pair_t p);
        ycc_pair_t y;
        y.first_luma  = luma_byte(p.first_blue, p.first_green, p.first_red);
        y.second_luma = luma_byte(p.second_blue, p.second_green, p.second_red);
        y.blue_chroma = pair_mean(cb_byte(p.first_blue, p.first_green, p.first_red),
                                  cb_byte(p.second_blue, p.second_green, p.second_red));
        y.red_chroma  = pair_mean(cr_byte(p.first_blue, p.first_green, p.first_red),
                                  cr_byte(p.second_blue, p.second_green, p.second_red));
        return y;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic bgr_pair_t random_pair();
        bgr_pair_t p;
        p.first_blue   = pick_byte();
        p.first_green  = pick_byte();
        p.first_red    = pick_byte();
        p.second_blue  = pick_byte();
        p.second_green = pick_byte();
        p.second_red   = pick_byte();
        return p;
    endfunction

    function automatic bgr_pair_t make_pair(input logic [7:0] b1, input logic [7:0] g1,
                                            input logic [7:0] r1, input logic [7:0] b2,
                                            input logic [7:0] g2, input logic [7:0] r2);
        bgr_pair_t p;
        p.first_blue   = b1;
        p.first_green  = g1;
        p.first_red    = r1;
        p.second_blue  = b2;
        p.second_green = g2;
        p.second_red   = r2;
        return p;
    endfunction

    task automatic send_pair(input bgr_pair_t p);
        while (!quiet && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ycc_due.push_back(bt601_pair(p));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (ycc_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_extremes();
        send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pair(make_pair(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pair(make_pair(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00));
        send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff));
        send_pair(make_pair(8'h01, 8'h01, 8'h01, 8'hfe, 8'hfe, 8'hfe));
        send_pair(make_pair(8'h80, 8'h80, 8'h80, 8'h7f, 8'h7f, 8'h7f));
        send_pair(make_pair(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55));
    endtask

    // largest and smallest chroma: pure blue, pure red and their complements, plus green, magenta and mixed pairs
    task automatic test_primaries();
        send_pair(make_pair(8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00));
        send_pair(make_pair(8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00));
        send_pair(make_pair(8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff));
        send_pair(make_pair(8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff));
        send_pair(make_pair(8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00));
        send_pair(make_pair(8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff));
        send_pair(make_pair(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff));
        send_pair(make_pair(8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00));
        send_pair(make_pair(8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff));
        send_pair(make_pair(8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff));
    endtask

    task automatic test_random_stream(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic test_no_idle_burst(input int count);
        quiet <= 1'b1;
        repeat (count) send_pair(random_pair());
        quiet <= 1'b0;
    endtask

    // output held off while input keeps coming, pipe fills and s_axis stalls
    task automatic test_output_hold(input int count);
        quiet    <= 1'b1;
        hold_req <= hold_req + 1;
        repeat (count) send_pair(random_pair());
        quiet    <= 1'b0;
    endtask

    task automatic test_drain_pause(input int count);
        repeat (count) send_pair(random_pair());
        wait_drained();
        repeat (count) send_pair(random_pair());
    endtask

    // ------------------------------------------------------------------------
    // result side: ready with random gaps and commanded hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (quiet)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        ycc_pair_t got;
        ycc_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            result_count++;
            if (ycc_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d with no request waiting: %h", result_count, got);
            end
            else
            begin
                want = ycc_due.pop_front();
                if (got.first_luma !== want.first_luma || got.second_luma !== want.second_luma
                    || got.blue_chroma !== want.blue_chroma
                    || got.red_chroma !== want.red_chroma)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d: y0 %h/%h y1 %h/%h cb %h/%h cr %h/%h (exp/got)",
                                 result_count, want.first_luma, got.first_luma,
                                 want.second_luma, got.second_luma,
                                 want.blue_chroma, got.blue_chroma,
                                 want.red_chroma, got.red_chroma);
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_primaries();
        test_random_stream(250);
        test_no_idle_burst(100);
        test_output_hold(40);
        test_drain_pause(30);
        test_random_stream(50);

        wait_drained();
        if (ycc_due.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("bgra_to_ycbcr422_pair_tb: done, clean");
        else
            $display("bgra_to_ycbcr422_pair_tb: done, errors");
        $finish;
    end

endmodule
